FILE: rtl/core/lnpm_pkg.sv
package lnpm_pkg;

    // largest opcode value, used by the constant pc add
    localparam logic [7:0] OPCODE_MAX = 8'd255;

    // bit-serial loops run one bit of an 8-bit value per cycle
    localparam int STEP_BITS = 8;
    localparam int CNT_W     = $clog2(STEP_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEP_BITS - 1);

    // reset values of the configuration registers
    localparam logic [7:0]        RST_MIN_INST_LENGTH = 8'd1;
    localparam logic              RST_DEFAULT_STMT    = 1'b1;
    localparam logic signed [7:0] RST_LINE_BASE       = -8'sd5;
    localparam logic [7:0]        RST_LINE_RANGE      = 8'd14;
    localparam logic [7:0]        RST_OPCODE_BASE     = 8'd13;

    // standard opcodes
    typedef enum logic [7:0] {
        OP_EXTENDED           = 8'd0,
        OP_COPY               = 8'd1,
        OP_ADVANCE_PC         = 8'd2,
        OP_ADVANCE_LINE       = 8'd3,
        OP_SET_FILE           = 8'd4,
        OP_SET_COLUMN         = 8'd5,
        OP_NEGATE_STMT        = 8'd6,
        OP_SET_BASIC_BLOCK    = 8'd7,
        OP_CONST_ADD_PC       = 8'd8,
        OP_FIXED_ADVANCE_PC   = 8'd9,
        OP_SET_PROLOGUE_END   = 8'd10,
        OP_SET_EPILOGUE_BEGIN = 8'd11,
        OP_SET_ISA            = 8'd12
    } opcode_t;

    // extended opcodes that do something
    typedef enum logic [7:0] {
        EXT_END_SEQUENCE = 8'd1,
        EXT_SET_ADDRESS  = 8'd2
    } ext_opcode_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_INST_LENGTH = 3'd0,
        CFG_DEFAULT_STMT    = 3'd1,
        CFG_LINE_BASE       = 3'd2,
        CFG_LINE_RANGE      = 3'd3,
        CFG_OPCODE_BASE     = 3'd4
    } cfg_index_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV,
        ST_MUL,
        ST_LINE_BASE,
        ST_LINE_REM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [7:0]        min_inst_length;
        logic              default_stmt;
        logic signed [7:0] line_min;
        logic [7:0]        line_span;
        logic [7:0]        opcode_base;
    } cfg_t;

    typedef struct packed {
        logic [63:0] address;
        logic [31:0] line;
        logic [31:0] file;
        logic [31:0] column;
        logic        is_stmt;
        logic        bblock;
        logic        seq_end;
        logic        prologue_end;
        logic        epi_begin;
        logic [31:0] isa;
    } row_t;

    // request to the shared adder: a + b + cin
    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic        cin;
    } alu_req_t;

endpackage

FILE: rtl/core/lnpm_instr_if.sv
interface lnpm_instr_if;
    logic        valid;
    logic        ready;
    logic [7:0]  func;
    logic [7:0]  ext_opcode;
    logic [63:0] operand;

    modport source (output valid, output func, output ext_opcode, output operand,
                    input ready);
    modport sink   (input valid, input func, input ext_opcode, input operand,
                    output ready);
endinterface

FILE: rtl/core/lnpm_row_if.sv
interface lnpm_row_if;
    logic        valid;
    logic        ready;
    logic [63:0] row_address;
    logic [31:0] row_line;
    logic [31:0] row_file;
    logic [31:0] row_column;
    logic        row_is_stmt;
    logic        row_basic_block;
    logic        row_end_sequence;
    logic        row_prologue_end;
    logic        row_epilogue_begin;
    logic [31:0] row_isa;

    modport source (output valid, output row_address, output row_line, output row_file,
                    output row_column, output row_is_stmt, output row_basic_block,
                    output row_end_sequence, output row_prologue_end,
                    output row_epilogue_begin, output row_isa, input ready);
    modport sink   (input valid, input row_address, input row_line, input row_file,
                    input row_column, input row_is_stmt, input row_basic_block,
                    input row_end_sequence, input row_prologue_end,
                    input row_epilogue_begin, input row_isa, output ready);
endinterface

FILE: rtl/core/lnpm_cfg_if.sv
interface lnpm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lnpm_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/line_number_program_machine.sv
// channel | modport | word
// --------+---------+-------------------------------------------------
// instr   | sink    | func, ext_opcode, operand: one decoded instruction
// row     | source  | row_address .. row_isa: one emitted line row
// cfg     | sink    | index, data: configuration register write
//
// One instruction at a time, accepted only in idle. Simple register ops, fixed pc advance
// and line advance finish in dispatch; copy and sequence end go on to emit; pc advance runs
// the multiply; constant pc add divides, then multiplies; special opcodes also add line
// base and remainder, then emit. Divide and shift-add multiply share the 64-bit adder.
// rst_n is asynchronous; the row registers and configuration take their initial
// values. A row waits in the emit state while the output register is still full.
module line_number_program_machine (
    input  logic        clk,
    input  logic        rst_n,
    lnpm_instr_if.sink  instr,
    lnpm_row_if.source  row,
    lnpm_cfg_if.sink    cfg
);
    import lnpm_pkg::*;

    cfg_t      cfg_reg;
    row_t      row_data_reg;
    logic      row_valid_reg;
    logic      out_free;
    logic      emit_load;
    row_t      emit_row;
    alu_req_t  alu_req;
    logic [64:0] alu_sum;

    // configuration writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_inst_length <= RST_MIN_INST_LENGTH;
            cfg_reg.default_stmt    <= RST_DEFAULT_STMT;
            cfg_reg.line_min        <= RST_LINE_BASE;
            cfg_reg.line_span       <= RST_LINE_RANGE;
            cfg_reg.opcode_base     <= RST_OPCODE_BASE;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MIN_INST_LENGTH: cfg_reg.min_inst_length <= cfg.data;
                CFG_DEFAULT_STMT:    cfg_reg.default_stmt    <= cfg.data[0];
                CFG_LINE_BASE:       cfg_reg.line_min        <= cfg.data;
                CFG_LINE_RANGE:      cfg_reg.line_span       <= cfg.data;
                CFG_OPCODE_BASE:     cfg_reg.opcode_base     <= cfg.data;
                default:             ;
            endcase
        end
    end

    // shared adder
    lnpm_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    // sequencer and row registers
    lnpm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_reg),
        .instr     (instr),
        .out_free  (out_free),
        .emit_load (emit_load),
        .emit_row  (emit_row),
        .alu_req   (alu_req),
        .alu_sum   (alu_sum)
    );

    // output register
    assign out_free = !row_valid_reg || row.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            row_valid_reg <= 1'b1;
        end
        else if (row.ready)
        begin
            row_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            row_data_reg <= emit_row;
        end
    end

    assign row.valid              = row_valid_reg;
    assign row.row_address        = row_data_reg.address;
    assign row.row_line           = row_data_reg.line;
    assign row.row_file           = row_data_reg.file;
    assign row.row_column         = row_data_reg.column;
    assign row.row_is_stmt        = row_data_reg.is_stmt;
    assign row.row_basic_block    = row_data_reg.bblock;
    assign row.row_end_sequence   = row_data_reg.seq_end;
    assign row.row_prologue_end   = row_data_reg.prologue_end;
    assign row.row_epilogue_begin = row_data_reg.epi_begin;
    assign row.row_isa            = row_data_reg.isa;

    // checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        instr.valid && instr.ready |=> !instr.ready)
        else $error("instruction accepted while previous one still running");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |-> (!row_valid_reg || row.ready))
        else $error("row loaded over an untaken row");

    a_ready_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |=> instr.ready && row.valid)
        else $error("emit did not return to idle with a valid row");

endmodule

FILE: rtl/core/lnpm_alu.sv
module lnpm_alu (
    input  lnpm_pkg::alu_req_t req,
    output logic [64:0]        sum
);
    import lnpm_pkg::*;

    // one 64-bit adder with carry out; subtraction comes in as ~b with cin set
    assign sum = {1'b0, req.a} + {1'b0, req.b} + {64'd0, req.cin};

endmodule

FILE: rtl/core/lnpm_core.sv
module lnpm_core (
    input  logic                clk,
    input  logic                rst_n,
    input  lnpm_pkg::cfg_t      cfg_regs,
    lnpm_instr_if.sink          instr,
    input  logic                out_free,
    output logic                emit_load,
    output lnpm_pkg::row_t      emit_row,
    output lnpm_pkg::alu_req_t  alu_req,
    input  logic [64:0]         alu_sum
);
    import lnpm_pkg::*;

    state_t            state_reg, state_next;
    logic [7:0]        func_reg, func_next;
    logic [7:0]        ext_reg, ext_next;
    logic [63:0]       operand_reg, operand_next;

    // row registers
    logic [63:0]       address_reg, address_next;
    logic [31:0]       line_reg, line_next;
    logic [31:0]       file_reg, file_next;
    logic [31:0]       column_reg, column_next;
    logic              stmt_reg, stmt_next;
    logic              bb_reg, bb_next;
    logic              pe_reg, pe_next;
    logic              eb_reg, eb_next;
    logic [31:0]       isa_reg, isa_next;

    // divide / multiply working registers
    logic [7:0]        dvd_reg, dvd_next;
    logic [7:0]        rem_reg, rem_next;
    logic [7:0]        quo_reg, quo_next;
    logic [63:0]       mul_m_reg, mul_m_next;
    logic [7:0]        mul_n_reg, mul_n_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              special_reg, special_next;
    logic              endseq_reg, endseq_next;

    logic [8:0]        div_shift;
    logic              div_ge;
    logic [7:0]        quo_step;

    assign instr.ready = (state_reg == ST_IDLE);

    assign emit_row = '{address:      address_reg,
                        line:         line_reg,
                        file:         file_reg,
                        column:       column_reg,
                        is_stmt:      stmt_reg,
                        bblock:       bb_reg,
                        seq_end:      endseq_reg,
                        prologue_end: pe_reg,
                        epi_begin:    eb_reg,
                        isa:          isa_reg};

    // divide step: shift in next dividend bit, trial subtract the line range
    assign div_shift = {rem_reg, dvd_reg[7]};
    assign div_ge    = alu_sum[64];
    assign quo_step  = {quo_reg[6:0], div_ge};

    // sequencer and datapath control
    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        ext_next     = ext_reg;
        operand_next = operand_reg;
        address_next = address_reg;
        line_next    = line_reg;
        file_next    = file_reg;
        column_next  = column_reg;
        stmt_next    = stmt_reg;
        bb_next      = bb_reg;
        pe_next      = pe_reg;
        eb_next      = eb_reg;
        isa_next     = isa_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        mul_m_next   = mul_m_reg;
        mul_n_next   = mul_n_reg;
        cnt_next     = cnt_reg;
        special_next = special_reg;
        endseq_next  = endseq_reg;
        emit_load    = 1'b0;
        alu_req      = '{a: address_reg, b: mul_m_reg, cin: 1'b0};

        case (state_reg)
            ST_IDLE:
            begin
                if (instr.valid)
                begin
                    func_next    = instr.func;
                    ext_next     = instr.ext_opcode;
                    operand_next = instr.operand;
                    state_next   = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                state_next  = ST_IDLE;
                endseq_next = 1'b0;
                cnt_next    = '0;
                rem_next    = '0;
                quo_next    = '0;
                case (func_reg)
                    OP_EXTENDED:
                    begin
                        if (ext_reg == EXT_END_SEQUENCE)
                        begin
                            endseq_next = 1'b1;
                            state_next  = ST_EMIT;
                        end
                        else if (ext_reg == EXT_SET_ADDRESS)
                        begin
                            address_next = operand_reg;
                        end
                    end
                    OP_COPY:
                    begin
                        state_next = ST_EMIT;
                    end
                    OP_ADVANCE_PC:
                    begin
                        mul_m_next   = operand_reg;
                        mul_n_next   = cfg_regs.min_inst_length;
                        special_next = 1'b0;
                        state_next   = ST_MUL;
                    end
                    OP_ADVANCE_LINE:
                    begin
                        alu_req   = '{a: {32'd0, line_reg}, b: {32'd0, operand_reg[31:0]},
                                      cin: 1'b0};
                        line_next = alu_sum[31:0];
                    end
                    OP_SET_FILE:           file_next   = operand_reg[31:0];
                    OP_SET_COLUMN:         column_next = operand_reg[31:0];
                    OP_NEGATE_STMT:        stmt_next   = ~stmt_reg;
                    OP_SET_BASIC_BLOCK:    bb_next     = 1'b1;
                    OP_CONST_ADD_PC:
                    begin
                        dvd_next     = OPCODE_MAX - cfg_regs.opcode_base;
                        special_next = 1'b0;
                        state_next   = ST_DIV;
                    end
                    OP_FIXED_ADVANCE_PC:
                    begin
                        alu_req      = '{a: address_reg, b: {48'd0, operand_reg[15:0]},
                                         cin: 1'b0};
                        address_next = alu_sum[63:0];
                    end
                    OP_SET_PROLOGUE_END:   pe_next     = 1'b1;
                    OP_SET_EPILOGUE_BEGIN: eb_next     = 1'b1;
                    OP_SET_ISA:            isa_next    = operand_reg[31:0];
                    default:
                    begin
                        // special opcode; unused standard opcodes fall through idle
                        if (func_reg >= cfg_regs.opcode_base)
                        begin
                            dvd_next     = func_reg - cfg_regs.opcode_base;
                            special_next = 1'b1;
                            state_next   = ST_DIV;
                        end
                    end
                endcase
            end

            ST_DIV:
            begin
                alu_req  = '{a: {55'd0, div_shift}, b: ~{56'd0, cfg_regs.line_span},
                             cin: 1'b1};
                rem_next = div_ge ? alu_sum[7:0] : div_shift[7:0];
                quo_next = quo_step;
                dvd_next = {dvd_reg[6:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    // zero line range: quotient 0, remainder already equals dividend
                    mul_m_next = (cfg_regs.line_span == 8'd0) ? 64'd0 : {56'd0, quo_step};
                    mul_n_next = cfg_regs.min_inst_length;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                // shift-add: address += mul_m << i for each set bit of mul_n
                alu_req = '{a: address_reg, b: mul_m_reg, cin: 1'b0};
                if (mul_n_reg[0])
                begin
                    address_next = alu_sum[63:0];
                end
                mul_m_next = {mul_m_reg[62:0], 1'b0};
                mul_n_next = {1'b0, mul_n_reg[7:1]};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = special_reg ? ST_LINE_BASE : ST_IDLE;
                end
            end

            ST_LINE_BASE:
            begin
                alu_req    = '{a: {32'd0, line_reg},
                               b: {32'd0, {24{cfg_regs.line_min[7]}}, cfg_regs.line_min},
                               cin: 1'b0};
                line_next  = alu_sum[31:0];
                state_next = ST_LINE_REM;
            end

            ST_LINE_REM:
            begin
                alu_req    = '{a: {32'd0, line_reg}, b: {56'd0, rem_reg}, cin: 1'b0};
                line_next  = alu_sum[31:0];
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit_load = 1'b1;
                    bb_next   = 1'b0;
                    pe_next   = 1'b0;
                    eb_next   = 1'b0;
                    if (endseq_reg)
                    begin
                        address_next = '0;
                        line_next    = 32'd1;
                        file_next    = 32'd1;
                        column_next  = '0;
                        stmt_next    = cfg_regs.default_stmt;
                        isa_next     = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and row registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            address_reg <= '0;
            line_reg    <= 32'd1;
            file_reg    <= 32'd1;
            column_reg  <= '0;
            stmt_reg    <= RST_DEFAULT_STMT;
            bb_reg      <= 1'b0;
            pe_reg      <= 1'b0;
            eb_reg      <= 1'b0;
            isa_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            address_reg <= address_next;
            line_reg    <= line_next;
            file_reg    <= file_next;
            column_reg  <= column_next;
            stmt_reg    <= stmt_next;
            bb_reg      <= bb_next;
            pe_reg      <= pe_next;
            eb_reg      <= eb_next;
            isa_reg     <= isa_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        ext_reg     <= ext_next;
        operand_reg <= operand_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        mul_m_reg   <= mul_m_next;
        mul_n_reg   <= mul_n_next;
        special_reg <= special_next;
        endseq_reg  <= endseq_next;
    end

endmodule
